>>> rtl/core/aes_rt_pkg.sv
// Package for the AES round transform: types, function codes and GF(2^8) helpers.
package aes_rt_pkg;

  localparam int NB = 4;
  localparam int NBYTES = 4 * NB;

  localparam logic [2:0] FUNC_ENC_ROUND = 3'd0;
  localparam logic [2:0] FUNC_ENC_FINAL = 3'd1;
  localparam logic [2:0] FUNC_DEC_ROUND = 3'd2;
  localparam logic [2:0] FUNC_DEC_FINAL = 3'd3;
  localparam logic [2:0] FUNC_ADD_KEY   = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] state_upper;
    logic [63:0] state_lower;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
  } aes_req_t;

  typedef struct packed {
    logic [63:0] result_upper;
    logic [63:0] result_lower;
  } aes_rsp_t;

  typedef struct packed {
    logic fwd;
    logic inv;
    logic mix;
  } aes_lane_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gf_mul = r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 1; i < 8; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_fwd_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_fwd_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv_calc(input logic [7:0] x);
    sbox_inv_calc = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t build_fwd();
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_fwd_calc(8'(i));
    build_fwd = t;
  endfunction

  function automatic sbox_arr_t build_inv();
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_inv_calc(8'(i));
    build_inv = t;
  endfunction

  localparam sbox_arr_t SBOX_FWD = build_fwd();
  localparam sbox_arr_t SBOX_INV = build_inv();

endpackage

>>> rtl/core/aes_rt_lane.sv
// One column lane: substitution, key addition and column mix for four bytes.
module aes_rt_lane
  import aes_rt_pkg::*;
(
  input  aes_lane_ctl_t ctl,
  input  logic [31:0]   col,
  input  logic [31:0]   key,
  output logic [31:0]   res
);

  logic [7:0] sb [4];
  logic [7:0] ak [4];
  logic [7:0] mx [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (ctl.fwd) sb[r] = SBOX_FWD[col[31-8*r -: 8]];
      else if (ctl.inv) sb[r] = SBOX_INV[col[31-8*r -: 8]];
      else sb[r] = col[31-8*r -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      // forward: mix before key; inverse: key before mix
      if (ctl.fwd) ak[r] = sb[r];
      else ak[r] = sb[r] ^ key[31-8*r -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      if (ctl.mix && ctl.fwd)
        mx[r] = xtime(ak[r]) ^ xtime(ak[(r+1)%4]) ^ ak[(r+1)%4] ^ ak[(r+2)%4] ^ ak[(r+3)%4];
      else if (ctl.mix && ctl.inv)
        mx[r] = gf_mul(8'h0e, ak[r]) ^ gf_mul(8'h0b, ak[(r+1)%4])
              ^ gf_mul(8'h0d, ak[(r+2)%4]) ^ gf_mul(8'h09, ak[(r+3)%4]);
      else
        mx[r] = ak[r];
    end
    for (int r = 0; r < 4; r++) begin
      res[31-8*r -: 8] = ctl.fwd ? (mx[r] ^ key[31-8*r -: 8]) : mx[r];
    end
  end

endmodule

>>> rtl/core/aes_round_transform.sv
// Top level of the AES round transform: row shift, four column lanes and output register.
//
// One AES round (forward, forward final, inverse, inverse final, or key
// addition alone) per request, selected by func; codes 5 to 7 add the key
// only. The result of each accepted request is in the output register in the
// cycle after it is accepted. Throughput is one request per cycle unless
// out_ready stalls a held result; one register stage follows the four column
// lanes. A new request is taken whenever the output register is empty or is
// being drained in the same cycle. State and key bytes are row-major
// (byte 4*row+col), byte 0 in the top bits of the upper word.
module aes_round_transform
  import aes_rt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  aes_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output aes_rsp_t out_data
);

  logic [7:0]    st [NBYTES];
  logic [7:0]    kb [NBYTES];
  logic [7:0]    sh [NBYTES];
  logic [31:0]   lane_col [NB];
  logic [31:0]   lane_key [NB];
  logic [31:0]   lane_res [NB];
  logic [127:0]  merged;
  aes_lane_ctl_t ctl;
  logic          take;

  always_comb begin
    ctl.fwd = (in_data.func == FUNC_ENC_ROUND) || (in_data.func == FUNC_ENC_FINAL);
    ctl.inv = (in_data.func == FUNC_DEC_ROUND) || (in_data.func == FUNC_DEC_FINAL);
    ctl.mix = (in_data.func == FUNC_ENC_ROUND) || (in_data.func == FUNC_DEC_ROUND);
  end

  // unpack and rotate rows; S-box is bytewise, so shifting first is equivalent
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      st[i]     = in_data.state_upper[63-8*i -: 8];
      st[8 + i] = in_data.state_lower[63-8*i -: 8];
      kb[i]     = in_data.key_upper[63-8*i -: 8];
      kb[8 + i] = in_data.key_lower[63-8*i -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < NB; c++) begin
        if (ctl.fwd) sh[NB*r + c] = st[NB*r + (c + r) % NB];
        else if (ctl.inv) sh[NB*r + c] = st[NB*r + (c - r + NB) % NB];
        else sh[NB*r + c] = st[NB*r + c];
      end
    end
    for (int c = 0; c < NB; c++) begin
      lane_col[c] = {sh[c], sh[NB + c], sh[2*NB + c], sh[3*NB + c]};
      lane_key[c] = {kb[c], kb[NB + c], kb[2*NB + c], kb[3*NB + c]};
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_lane
    aes_rt_lane u_lane (
      .ctl (ctl),
      .col (lane_col[g]),
      .key (lane_key[g]),
      .res (lane_res[g])
    );
  end

  // merge columns back to row-major order
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < NB; c++) begin
        merged[127-8*(NB*r + c) -: 8] = lane_res[c][31-8*r -: 8];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (take) begin
      out_data <= {merged[127:64], merged[63:0]};
    end
  end

`ifndef NO_ASSERTIONS
  a_take_sets_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid) else $error("accepted request gave no result");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("not ready while empty");
`endif

endmodule
